### hdl/gmc_pkg.sv
package gmc_pkg;

    localparam int OP_WIDTH      = 4;
    localparam int BLINK_WIDTH   = 8;
    localparam int TIMEOUT_WIDTH = 12;
    localparam int CFG_DATA_WIDTH = 12;
    localparam int CFG_INDEX_WIDTH = 2;

    // Number of equal samples that make the button level stable.
    localparam logic [1:0] SETTLE_COUNT = 2'd2;

    localparam logic [BLINK_WIDTH-1:0]   OPEN_BLINK_RESET   = 8'd5;
    localparam logic [BLINK_WIDTH-1:0]   CLOSE_BLINK_RESET  = 8'd2;
    localparam logic [BLINK_WIDTH-1:0]   ERROR_BLINK_RESET  = 8'd5;
    localparam logic [TIMEOUT_WIDTH-1:0] TRAVEL_TIMEOUT_RESET = 12'd120;

    typedef enum logic [2:0] {
        GATE_UNKNOWN = 3'd0,
        GATE_CLOSED  = 3'd1,
        GATE_OPENING = 3'd2,
        GATE_OPEN    = 3'd3,
        GATE_CLOSING = 3'd4,
        GATE_ERROR   = 3'd5
    } gate_mode_t;

    typedef enum logic [1:0] {
        DIR_STOP  = 2'd0,
        DIR_OPEN  = 2'd1,
        DIR_CLOSE = 2'd2
    } motor_dir_t;

    typedef enum logic [1:0] {
        FAULT_NONE          = 2'd0,
        FAULT_LIMITS        = 2'd1,
        FAULT_OPEN_TIMEOUT  = 2'd2,
        FAULT_CLOSE_TIMEOUT = 2'd3
    } fault_t;

    typedef enum logic [3:0] {
        OP_TICK     = 4'd0,
        OP_BOOT     = 4'd1,
        OP_OPEN     = 4'd2,
        OP_CLOSE    = 4'd3,
        OP_STOP     = 4'd4,
        OP_PP       = 4'd5,
        OP_LAMP_ON  = 4'd6,
        OP_LAMP_OFF = 4'd7,
        OP_BUZZ_ON  = 4'd8,
        OP_BUZZ_OFF = 4'd9,
        OP_RESET    = 4'd10,
        OP_GET      = 4'd11
    } op_t;

    typedef enum logic [3:0] {
        RSN_BOOT          = 4'd0,
        RSN_CMD_OPEN      = 4'd1,
        RSN_CMD_CLOSE     = 4'd2,
        RSN_CMD_STOP      = 4'd3,
        RSN_CMD_PP        = 4'd4,
        RSN_CMD_RESET     = 4'd5,
        RSN_CMD_GET       = 4'd6,
        RSN_ERR_LIMITS    = 4'd7,
        RSN_OPENED        = 4'd8,
        RSN_CLOSED        = 4'd9,
        RSN_TIMEOUT_OPEN  = 4'd10,
        RSN_TIMEOUT_CLOSE = 4'd11,
        RSN_NONE          = 4'd12
    } reason_t;

    typedef enum logic [1:0] {
        CFG_OPEN_BLINK     = 2'd0,
        CFG_CLOSE_BLINK    = 2'd1,
        CFG_ERROR_BLINK    = 2'd2,
        CFG_TRAVEL_TIMEOUT = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic [BLINK_WIDTH-1:0]   open_blink;
        logic [BLINK_WIDTH-1:0]   close_blink;
        logic [BLINK_WIDTH-1:0]   error_blink;
        logic [TIMEOUT_WIDTH-1:0] travel_timeout;
    } cfg_t;

    // Gate state apart from the travel counter, whose width is a parameter.
    typedef struct packed {
        gate_mode_t             mode;
        fault_t                 fault;
        logic [BLINK_WIDTH-1:0] blink_count;
        logic                   blink_phase;
        logic                   buzz_phase;
        logic                   lamp;
        logic                   buzzer;
        motor_dir_t             dir;
    } gate_state_t;

    typedef struct packed {
        logic       motor_open;
        logic       motor_close;
        logic       lamp;
        logic       buzzer;
        gate_mode_t gate_state;
        fault_t     error_code;
        logic       button_report;
        logic       report;
        reason_t    reason;
    } result_t;

endpackage

### hdl/gmc_if.sv
interface gmc_cmd_if;
    logic                          valid;
    logic                          ready;
    logic [gmc_pkg::OP_WIDTH-1:0]  op;
    logic                          button_level;
    logic                          limit_open;
    logic                          limit_close;

    modport source (output valid, output op, output button_level, output limit_open,
                    output limit_close, input ready);
    modport sink   (input valid, input op, input button_level, input limit_open,
                    input limit_close, output ready);
endinterface

interface gmc_result_if;
    logic       valid;
    logic       ready;
    logic       motor_open;
    logic       motor_close;
    logic       lamp;
    logic       buzzer;
    logic [2:0] gate_state;
    logic [1:0] error_code;
    logic       button_report;
    logic       report;
    logic [3:0] reason;

    modport source (output valid, output motor_open, output motor_close, output lamp,
                    output buzzer, output gate_state, output error_code,
                    output button_report, output report, output reason, input ready);
    modport sink   (input valid, input motor_open, input motor_close, input lamp,
                    input buzzer, input gate_state, input error_code,
                    input button_report, input report, input reason, output ready);
endinterface

### hdl/gate_motor_controller.sv
// Gate motor controller.
//
// Events arrive on the cmd channel (valid/ready): a 100 ms tick, a boot
// indication or a command, each carrying the raw button level and both limit
// switch levels. Every accepted request yields exactly one request on the
// result channel with the motor drive, lamp, buzzer, gate state, fault code and
// the report flag and reason for this event.
//
// A request is captured in an input register, and the gate state update is
// done in one pass of logic from there into the result register, from which
// the result is offered. While the result receiver takes every result, a new
// request can be accepted in every cycle, so the sustained rate is one event
// per clock.
//
// When the result receiver stalls, the pending event stays in the input
// register and cmd.ready drops only while both registers are full.
// The user must write the blink and timeout registers on the cfg port only
// while the block is idle; the block itself does not enforce it. Reset puts
// the gate in the unknown state with the motor stopped, lamp and buzzer off,
// the debounced button released and the registers at their default values.
module gate_motor_controller #(
    parameter int TRAVEL_WIDTH = 12
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    gmc_cmd_if.sink                              cmd,
    gmc_result_if.source                         result,
    input  logic                                 cfg_we,
    input  logic [gmc_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
    input  logic [gmc_pkg::CFG_DATA_WIDTH-1:0]   cfg_data
);
    import gmc_pkg::*;

    // Input stage.
    logic                s1_valid_reg, s1_valid_next;
    logic [OP_WIDTH-1:0] s1_op_reg;
    logic                s1_button_reg;
    logic                s1_limit_open_reg;
    logic                s1_limit_close_reg;

    // Gate state and configuration.
    gate_state_t             state_reg, state_next;
    logic [TRAVEL_WIDTH-1:0] travel_reg, travel_next;
    cfg_t                    cfg_reg, cfg_next;

    // Result stage.
    logic    out_valid_reg, out_valid_next;
    result_t out_reg;
    result_t step_result;

    logic cmd_accept;
    logic advance;
    logic press;

    // The event in the input stage moves on whenever the result register is
    // free or is being emptied in this cycle.
    assign advance    = s1_valid_reg && (!out_valid_reg || result.ready);
    assign cmd.ready  = !s1_valid_reg || advance;
    assign cmd_accept = cmd.valid && cmd.ready;

    always_comb
    begin
        if (cmd_accept)
            s1_valid_next = 1'b1;
        else if (advance)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;

        if (advance)
            out_valid_next = 1'b1;
        else if (result.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // The debouncer samples the button only on ticks.
    gmc_debounce u_debounce (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample_en (advance && (s1_op_reg == OP_TICK)),
        .raw       (s1_button_reg),
        .press     (press)
    );

    gmc_step #(
        .TRAVEL_WIDTH (TRAVEL_WIDTH)
    ) u_step (
        .st          (state_reg),
        .travel      (travel_reg),
        .cfg         (cfg_reg),
        .op          (s1_op_reg),
        .press       (press),
        .limit_open  (s1_limit_open_reg),
        .limit_close (s1_limit_close_reg),
        .st_next     (state_next),
        .travel_next (travel_next),
        .res         (step_result)
    );

    // Configuration writes; each register keeps only its own width.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                CFG_OPEN_BLINK:     cfg_next.open_blink     = cfg_data[BLINK_WIDTH-1:0];
                CFG_CLOSE_BLINK:    cfg_next.close_blink    = cfg_data[BLINK_WIDTH-1:0];
                CFG_ERROR_BLINK:    cfg_next.error_blink    = cfg_data[BLINK_WIDTH-1:0];
                CFG_TRAVEL_TIMEOUT: cfg_next.travel_timeout = cfg_data[TIMEOUT_WIDTH-1:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg           <= 1'b0;
            out_valid_reg          <= 1'b0;
            state_reg.mode         <= GATE_UNKNOWN;
            state_reg.fault        <= FAULT_NONE;
            state_reg.blink_count  <= '0;
            state_reg.blink_phase  <= 1'b0;
            state_reg.buzz_phase   <= 1'b0;
            state_reg.lamp         <= 1'b0;
            state_reg.buzzer       <= 1'b0;
            state_reg.dir          <= DIR_STOP;
            travel_reg             <= '0;
            cfg_reg.open_blink     <= OPEN_BLINK_RESET;
            cfg_reg.close_blink    <= CLOSE_BLINK_RESET;
            cfg_reg.error_blink    <= ERROR_BLINK_RESET;
            cfg_reg.travel_timeout <= TRAVEL_TIMEOUT_RESET;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            cfg_reg       <= cfg_next;
            if (advance)
            begin
                state_reg  <= state_next;
                travel_reg <= travel_next;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (cmd_accept)
        begin
            s1_op_reg          <= cmd.op;
            s1_button_reg      <= cmd.button_level;
            s1_limit_open_reg  <= cmd.limit_open;
            s1_limit_close_reg <= cmd.limit_close;
        end
        if (advance)
            out_reg <= step_result;
    end

    assign result.valid         = out_valid_reg;
    assign result.motor_open    = out_reg.motor_open;
    assign result.motor_close   = out_reg.motor_close;
    assign result.lamp          = out_reg.lamp;
    assign result.buzzer        = out_reg.buzzer;
    assign result.gate_state    = out_reg.gate_state;
    assign result.error_code    = out_reg.error_code;
    assign result.button_report = out_reg.button_report;
    assign result.report        = out_reg.report;
    assign result.reason        = out_reg.reason;

    // The input side stalls only when a finished result is held back.
    a_ready_only_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.ready |-> (result.valid && !result.ready))
        else $error("cmd.ready low without a stalled result");

    // The motor is never driven while the gate is in the error state.
    a_no_drive_in_error: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && (result.gate_state == GATE_ERROR)) |->
        (!result.motor_open && !result.motor_close))
        else $error("motor driven in error state");

    // Every way into the error state records a fault code.
    a_error_has_fault: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && (result.gate_state == GATE_ERROR)) |->
        (result.error_code != FAULT_NONE))
        else $error("error state without a fault code");

endmodule

### hdl/gmc_debounce.sv
module gmc_debounce (
    input  logic clk,
    input  logic rst_n,
    input  logic sample_en,
    input  logic raw,
    output logic press
);
    import gmc_pkg::*;

    logic [1:0] stable_count_reg, stable_count_next;
    logic       last_sample_reg, last_sample_next;
    logic       debounced_reg, debounced_next;
    logic [1:0] count_step;

    always_comb
    begin
        if (raw == last_sample_reg)
        begin
            count_step       = (stable_count_reg < SETTLE_COUNT) ?
                               stable_count_reg + 2'd1 : stable_count_reg;
            last_sample_next = last_sample_reg;
        end
        else
        begin
            count_step       = 2'd0;
            last_sample_next = raw;
        end
        if (count_step >= SETTLE_COUNT)
        begin
            debounced_next    = raw;
            stable_count_next = 2'd0;
        end
        else
        begin
            debounced_next    = debounced_reg;
            stable_count_next = count_step;
        end
    end

    // A press is a high-to-low change of the debounced level.
    assign press = debounced_reg && !debounced_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stable_count_reg <= 2'd0;
            last_sample_reg  <= 1'b1;
            debounced_reg    <= 1'b1;
        end
        else if (sample_en)
        begin
            stable_count_reg <= stable_count_next;
            last_sample_reg  <= last_sample_next;
            debounced_reg    <= debounced_next;
        end
    end

endmodule

### hdl/gmc_step.sv
module gmc_step #(
    parameter int TRAVEL_WIDTH = 12
) (
    input  gmc_pkg::gate_state_t         st,
    input  logic [TRAVEL_WIDTH-1:0]      travel,
    input  gmc_pkg::cfg_t                cfg,
    input  logic [gmc_pkg::OP_WIDTH-1:0] op,
    input  logic                         press,
    input  logic                         limit_open,
    input  logic                         limit_close,
    output gmc_pkg::gate_state_t         st_next,
    output logic [TRAVEL_WIDTH-1:0]      travel_next,
    output gmc_pkg::result_t             res
);
    import gmc_pkg::*;

    localparam int CMP_WIDTH = (TRAVEL_WIDTH > TIMEOUT_WIDTH) ? TRAVEL_WIDTH : TIMEOUT_WIDTH;
    localparam logic [TRAVEL_WIDTH-1:0] TRAVEL_MAX = {TRAVEL_WIDTH{1'b1}};

    gate_mode_t              pressed_mode;
    gate_mode_t              tick_mode;
    logic [BLINK_WIDTH-1:0]  blink_period;
    logic [BLINK_WIDTH-1:0]  blink_inc;
    logic                    blink_toggle;
    logic [BLINK_WIDTH-1:0]  blink_after;
    logic                    phase_after;
    logic                    lamp_after;
    logic [TRAVEL_WIDTH-1:0] travel_inc;
    logic                    timed_out;
    logic                    opening;
    logic                    at_end;
    gate_state_t             s;
    logic                    btn_rep;
    logic                    report;
    reason_t                 reason;

    // Effect of a button press or a pp command on the mode.
    always_comb
    begin
        case (st.mode)
            GATE_CLOSED:  pressed_mode = GATE_OPENING;
            GATE_OPEN:    pressed_mode = GATE_CLOSING;
            GATE_UNKNOWN: pressed_mode = GATE_CLOSING;
            default:      pressed_mode = st.mode;
        endcase
    end

    // The tick acts on the mode after any press of the same tick.
    assign tick_mode = press ? pressed_mode : st.mode;
    assign opening   = (tick_mode == GATE_OPENING);
    assign at_end    = opening ? limit_open : limit_close;

    always_comb
    begin
        case (tick_mode)
            GATE_OPENING: blink_period = cfg.open_blink;
            GATE_CLOSING: blink_period = cfg.close_blink;
            default:      blink_period = cfg.error_blink;
        endcase
    end

    assign blink_inc    = st.blink_count + 8'd1;
    assign blink_toggle = (blink_inc >= blink_period);
    assign blink_after  = blink_toggle ? '0 : blink_inc;
    assign phase_after  = st.blink_phase ^ blink_toggle;
    assign lamp_after   = blink_toggle ? phase_after : st.lamp;

    assign travel_inc = (travel == TRAVEL_MAX) ? travel : travel + TRAVEL_WIDTH'(1);
    assign timed_out  = (CMP_WIDTH'(travel_inc) >= CMP_WIDTH'(cfg.travel_timeout));

    always_comb
    begin
        s           = st;
        travel_next = travel;
        btn_rep     = 1'b0;
        report      = 1'b0;
        reason      = RSN_NONE;
        case (op_t'(op))
            OP_TICK:
            begin
                s.mode  = tick_mode;
                btn_rep = press;
                if (tick_mode inside {GATE_OPENING, GATE_CLOSING})
                begin
                    if (limit_open && limit_close)
                    begin
                        s.fault = FAULT_LIMITS;
                        s.mode  = GATE_ERROR;
                        s.dir   = DIR_STOP;
                        reason  = RSN_ERR_LIMITS;
                    end
                    else
                    begin
                        s.blink_count = blink_after;
                        s.blink_phase = phase_after;
                        if (at_end)
                        begin
                            s.dir       = DIR_STOP;
                            s.mode      = opening ? GATE_OPEN : GATE_CLOSED;
                            travel_next = '0;
                            s.lamp      = opening;
                            reason      = opening ? RSN_OPENED : RSN_CLOSED;
                        end
                        else if (timed_out)
                        begin
                            travel_next = travel_inc;
                            s.lamp      = lamp_after;
                            s.dir       = DIR_STOP;
                            s.fault     = opening ? FAULT_OPEN_TIMEOUT : FAULT_CLOSE_TIMEOUT;
                            s.mode      = GATE_ERROR;
                            reason      = opening ? RSN_TIMEOUT_OPEN : RSN_TIMEOUT_CLOSE;
                        end
                        else
                        begin
                            travel_next = travel_inc;
                            s.lamp      = lamp_after;
                            s.dir       = opening ? DIR_OPEN : DIR_CLOSE;
                        end
                    end
                end
                else if (tick_mode == GATE_ERROR)
                begin
                    s.dir         = DIR_STOP;
                    s.blink_count = blink_after;
                    s.blink_phase = phase_after;
                    s.lamp        = lamp_after;
                    s.buzz_phase  = !st.buzz_phase;
                    s.buzzer      = !st.buzz_phase;
                end
                else
                begin
                    s.dir         = DIR_STOP;
                    s.lamp        = (tick_mode == GATE_OPEN);
                    s.blink_count = '0;
                    travel_next   = '0;
                end
                report = press || (reason != RSN_NONE);
            end
            OP_BOOT:
            begin
                if (limit_open && limit_close)
                begin
                    s.mode  = GATE_ERROR;
                    s.fault = FAULT_LIMITS;
                end
                else if (limit_open)
                    s.mode = GATE_OPEN;
                else if (limit_close)
                    s.mode = GATE_CLOSED;
                else
                    s.mode = GATE_UNKNOWN;
                s.blink_count = '0;
                travel_next   = '0;
                s.blink_phase = 1'b0;
                s.buzz_phase  = 1'b0;
                s.dir         = DIR_STOP;
                s.lamp        = 1'b0;
                s.buzzer      = 1'b0;
                report        = 1'b1;
                reason        = RSN_BOOT;
            end
            OP_OPEN:
            begin
                if (st.mode inside {GATE_CLOSED, GATE_UNKNOWN})
                begin
                    s.mode = GATE_OPENING;
                    report = 1'b1;
                    reason = RSN_CMD_OPEN;
                end
            end
            OP_CLOSE:
            begin
                if (st.mode inside {GATE_OPEN, GATE_UNKNOWN})
                begin
                    s.mode = GATE_CLOSING;
                    report = 1'b1;
                    reason = RSN_CMD_CLOSE;
                end
            end
            OP_STOP:
            begin
                s.dir  = DIR_STOP;
                s.mode = GATE_UNKNOWN;
                report = 1'b1;
                reason = RSN_CMD_STOP;
            end
            OP_PP:
            begin
                s.mode = pressed_mode;
                report = 1'b1;
                reason = RSN_CMD_PP;
            end
            OP_LAMP_ON:  s.lamp   = 1'b1;
            OP_LAMP_OFF: s.lamp   = 1'b0;
            OP_BUZZ_ON:  s.buzzer = 1'b1;
            OP_BUZZ_OFF: s.buzzer = 1'b0;
            OP_RESET:
            begin
                s.fault  = FAULT_NONE;
                s.mode   = GATE_UNKNOWN;
                s.dir    = DIR_STOP;
                s.lamp   = 1'b0;
                s.buzzer = 1'b0;
                report   = 1'b1;
                reason   = RSN_CMD_RESET;
            end
            OP_GET:
            begin
                report = 1'b1;
                reason = RSN_CMD_GET;
            end
            default:
            begin
                report = 1'b0;
            end
        endcase
    end

    assign st_next = s;

    always_comb
    begin
        res.motor_open    = (s.dir == DIR_OPEN);
        res.motor_close   = (s.dir == DIR_CLOSE);
        res.lamp          = s.lamp;
        res.buzzer        = s.buzzer;
        res.gate_state    = s.mode;
        res.error_code    = s.fault;
        res.button_report = btn_rep;
        res.report        = report;
        res.reason        = reason;
    end

endmodule

### tb/tb_gate_motor_controller.sv
`timescale 1ns / 100ps

// Self-checking bench for the gate motor controller.
//
// An initial block fills a queue of pending event requests: a short
// directed sequence, then several random phases. A clocked driver hands
// them to the cmd channel. Each accepted request is run through a
// cycle-free model of the gate logic kept in this module, and its outputs
// are queued. A clocked monitor takes every result request and checks it
// field by field against the oldest queued prediction.
module tb_gate_motor_controller;
    import gmc_pkg::*;

    localparam int          CYCLE_LIMIT  = 300000;
    localparam int          DRAIN_CYCLES = 8;
    localparam logic [11:0] TRAVEL_MAX   = 12'hFFF;

    // One event request as the driver presents it. When hold is set, the
    // driver keeps it back until every earlier request has its result.
    typedef struct {
        logic [OP_WIDTH-1:0] op;
        logic                button_level;
        logic                limit_open;
        logic                limit_close;
        bit                  hold;
    } gate_event_t;

    logic                       clk = 1'b0;
    logic                       rst_n;
    logic                       cfg_we;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index;
    logic [CFG_DATA_WIDTH-1:0]  cfg_data;

    gmc_cmd_if    cmd_bus ();
    gmc_result_if res_bus ();

    gate_motor_controller #(
        .TRAVEL_WIDTH (12)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd_bus),
        .result    (res_bus),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    gate_event_t gate_events[$];
    result_t     outputs_due[$];

    int unsigned tx_idle_pct;
    int unsigned rx_idle_pct;
    int unsigned error_count   = 0;
    int unsigned cycle_count   = 0;
    int unsigned events_queued = 0;

    // Shadow of the blink and timeout registers, and the model's gate state.
    // The registers only change while nothing is in flight.
    cfg_t        cfg_shadow;
    gate_state_t gs;
    logic [11:0] travel_cnt;
    logic [1:0]  stable_cnt;
    logic        last_sample;
    logic        debounced;
    logic        prev_debounced;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // A falling edge of the debounced button, or the pp command, starts the
    // gate from a resting state. A moving or failed gate ignores it.
    function automatic void press_button();
        case (gs.mode)
            GATE_CLOSED:  gs.mode = GATE_OPENING;
            GATE_OPEN:    gs.mode = GATE_CLOSING;
            GATE_UNKNOWN: gs.mode = GATE_CLOSING;
            default:      ;
        endcase
    endfunction

    // The blink counter wraps at 8 bits; a period of zero toggles every tick.
    function automatic void step_blink(logic [BLINK_WIDTH-1:0] period);
        gs.blink_count = gs.blink_count + 8'd1;
        if (gs.blink_count >= period)
        begin
            gs.blink_count = '0;
            gs.blink_phase = ~gs.blink_phase;
            gs.lamp        = gs.blink_phase;
        end
    endfunction

    // One tick of motion. Both limits at once win over everything, then the
    // limit at the end of travel, then the timeout.
    function automatic reason_t travel_tick(logic opening, logic lo, logic lc);
        logic at_end;
        at_end = opening ? lo : lc;
        if (lo && lc)
        begin
            gs.fault = FAULT_LIMITS;
            gs.mode  = GATE_ERROR;
            gs.dir   = DIR_STOP;
            return RSN_ERR_LIMITS;
        end
        gs.dir = opening ? DIR_OPEN : DIR_CLOSE;
        if (travel_cnt < TRAVEL_MAX)
            travel_cnt = travel_cnt + 12'd1;
        step_blink(opening ? cfg_shadow.open_blink : cfg_shadow.close_blink);
        if (at_end)
        begin
            gs.dir     = DIR_STOP;
            gs.mode    = opening ? GATE_OPEN : GATE_CLOSED;
            travel_cnt = '0;
            gs.lamp    = opening;
            return opening ? RSN_OPENED : RSN_CLOSED;
        end
        if (travel_cnt >= cfg_shadow.travel_timeout)
        begin
            gs.dir   = DIR_STOP;
            gs.fault = opening ? FAULT_OPEN_TIMEOUT : FAULT_CLOSE_TIMEOUT;
            gs.mode  = GATE_ERROR;
            return opening ? RSN_TIMEOUT_OPEN : RSN_TIMEOUT_CLOSE;
        end
        return RSN_NONE;
    endfunction

    // Applies one event to the model state and returns the outputs that the
    // block must report for it.
    function automatic result_t next_gate_outputs(logic [OP_WIDTH-1:0] op, logic btn,
                                                  logic lo, logic lc);
        result_t r;
        logic    pressed;
        r.button_report = 1'b0;
        r.report        = 1'b0;
        r.reason        = RSN_NONE;
        case (op)
            OP_TICK:
            begin
                // The raw level must repeat on two further ticks before the
                // debounced level follows it.
                if (btn == last_sample)
                begin
                    if (stable_cnt < SETTLE_COUNT)
                        stable_cnt = stable_cnt + 2'd1;
                end
                else
                begin
                    stable_cnt  = '0;
                    last_sample = btn;
                end
                if (stable_cnt >= SETTLE_COUNT)
                begin
                    debounced  = btn;
                    stable_cnt = '0;
                end
                pressed        = prev_debounced && !debounced;
                prev_debounced = debounced;
                if (pressed)
                begin
                    press_button();
                    r.button_report = 1'b1;
                    r.report        = 1'b1;
                end
                case (gs.mode)
                    GATE_OPENING: r.reason = travel_tick(1'b1, lo, lc);
                    GATE_CLOSING: r.reason = travel_tick(1'b0, lo, lc);
                    GATE_ERROR:
                    begin
                        gs.dir = DIR_STOP;
                        step_blink(cfg_shadow.error_blink);
                        gs.buzz_phase = ~gs.buzz_phase;
                        gs.buzzer     = gs.buzz_phase;
                    end
                    default:
                    begin
                        gs.dir         = DIR_STOP;
                        gs.lamp        = (gs.mode == GATE_OPEN);
                        gs.blink_count = '0;
                        travel_cnt     = '0;
                    end
                endcase
                if (r.reason != RSN_NONE)
                    r.report = 1'b1;
            end
            OP_BOOT:
            begin
                // The fault survives a boot unless both limits set it anew.
                if (lo && lc)
                begin
                    gs.mode  = GATE_ERROR;
                    gs.fault = FAULT_LIMITS;
                end
                else if (lo)
                    gs.mode = GATE_OPEN;
                else if (lc)
                    gs.mode = GATE_CLOSED;
                else
                    gs.mode = GATE_UNKNOWN;
                gs.blink_count = '0;
                travel_cnt     = '0;
                gs.blink_phase = 1'b0;
                gs.buzz_phase  = 1'b0;
                gs.dir         = DIR_STOP;
                gs.lamp        = 1'b0;
                gs.buzzer      = 1'b0;
                r.report       = 1'b1;
                r.reason       = RSN_BOOT;
            end
            OP_OPEN:
            begin
                if (gs.mode == GATE_CLOSED || gs.mode == GATE_UNKNOWN)
                begin
                    gs.mode  = GATE_OPENING;
                    r.report = 1'b1;
                    r.reason = RSN_CMD_OPEN;
                end
            end
            OP_CLOSE:
            begin
                if (gs.mode == GATE_OPEN || gs.mode == GATE_UNKNOWN)
                begin
                    gs.mode  = GATE_CLOSING;
                    r.report = 1'b1;
                    r.reason = RSN_CMD_CLOSE;
                end
            end
            OP_STOP:
            begin
                gs.dir   = DIR_STOP;
                gs.mode  = GATE_UNKNOWN;
                r.report = 1'b1;
                r.reason = RSN_CMD_STOP;
            end
            OP_PP:
            begin
                press_button();
                r.report = 1'b1;
                r.reason = RSN_CMD_PP;
            end
            OP_LAMP_ON:  gs.lamp   = 1'b1;
            OP_LAMP_OFF: gs.lamp   = 1'b0;
            OP_BUZZ_ON:  gs.buzzer = 1'b1;
            OP_BUZZ_OFF: gs.buzzer = 1'b0;
            OP_RESET:
            begin
                gs.fault  = FAULT_NONE;
                gs.mode   = GATE_UNKNOWN;
                gs.dir    = DIR_STOP;
                gs.lamp   = 1'b0;
                gs.buzzer = 1'b0;
                r.report  = 1'b1;
                r.reason  = RSN_CMD_RESET;
            end
            OP_GET:
            begin
                r.report = 1'b1;
                r.reason = RSN_CMD_GET;
            end
            default: ;
        endcase
        r.motor_open  = (gs.dir == DIR_OPEN);
        r.motor_close = (gs.dir == DIR_CLOSE);
        r.lamp        = gs.lamp;
        r.buzzer      = gs.buzzer;
        r.gate_state  = gs.mode;
        r.error_code  = gs.fault;
        return r;
    endfunction

    function automatic void check_field(string field, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", field, want, got);
            error_count++;
        end
    endfunction

    // Only events that the block acts on count toward the size of a phase.
    function automatic void add_event(logic [OP_WIDTH-1:0] op, logic btn, logic lo,
                                      logic lc, bit hold);
        gate_event_t ev;
        ev.op           = op;
        ev.button_level = btn;
        ev.limit_open   = lo;
        ev.limit_close  = lc;
        ev.hold         = hold;
        gate_events.push_back(ev);
        if (op <= OP_GET)
            events_queued++;
    endfunction

    // Driver. The prediction is made at the edge where the request is
    // accepted, so it sees exactly the fields the block captured. A new
    // request is offered only when the channel is free or just moved one.
    always @(posedge clk or negedge rst_n)
    begin
        gate_event_t ev;
        if (!rst_n)
        begin
            cmd_bus.valid        <= 1'b0;
            cmd_bus.op           <= '0;
            cmd_bus.button_level <= 1'b1;
            cmd_bus.limit_open   <= 1'b0;
            cmd_bus.limit_close  <= 1'b0;
            gs                   = '0;
            travel_cnt           = '0;
            stable_cnt           = '0;
            last_sample          = 1'b1;
            debounced            = 1'b1;
            prev_debounced       = 1'b1;
        end
        else
        begin
            if (cmd_bus.valid && cmd_bus.ready)
                outputs_due.push_back(next_gate_outputs(cmd_bus.op, cmd_bus.button_level,
                                                        cmd_bus.limit_open,
                                                        cmd_bus.limit_close));
            if (!cmd_bus.valid || cmd_bus.ready)
            begin
                if (gate_events.size() != 0 && $urandom_range(99) >= tx_idle_pct &&
                    !(gate_events[0].hold && outputs_due.size() != 0))
                begin
                    ev = gate_events.pop_front();
                    cmd_bus.valid        <= 1'b1;
                    cmd_bus.op           <= ev.op;
                    cmd_bus.button_level <= ev.button_level;
                    cmd_bus.limit_open   <= ev.limit_open;
                    cmd_bus.limit_close  <= ev.limit_close;
                end
                else
                    cmd_bus.valid <= 1'b0;
            end
        end
    end

    // Monitor. Every result request must match the oldest prediction; the
    // ready level is redrawn at each edge to stall the block at random.
    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
            res_bus.ready <= 1'b0;
        else
        begin
            if (res_bus.valid && res_bus.ready)
            begin
                if (outputs_due.size() == 0)
                begin
                    $error("result request with no event request outstanding");
                    error_count++;
                end
                else
                begin
                    want = outputs_due.pop_front();
                    check_field("motor_open", want.motor_open, res_bus.motor_open);
                    check_field("motor_close", want.motor_close, res_bus.motor_close);
                    check_field("lamp", want.lamp, res_bus.lamp);
                    check_field("buzzer", want.buzzer, res_bus.buzzer);
                    check_field("gate_state", want.gate_state, res_bus.gate_state);
                    check_field("error_code", want.error_code, res_bus.error_code);
                    check_field("button_report", want.button_report, res_bus.button_report);
                    check_field("report", want.report, res_bus.report);
                    check_field("reason", want.reason, res_bus.reason);
                end
            end
            res_bus.ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Watchdog for a hung handshake.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $error("no progress within %0d cycles", CYCLE_LIMIT);
            $display("status: fail");
            $finish;
        end
    end

    // Sampling at the falling edge keeps this clear of the driver's and the
    // monitor's updates at the rising edge.
    task automatic wait_until_drained();
        do
            @(negedge clk);
        while (gate_events.size() != 0 || outputs_due.size() != 0 || cmd_bus.valid);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(cfg_reg_t index, logic [CFG_DATA_WIDTH-1:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // The blink registers keep only the low 8 bits, so the upper data bits
    // are filled with junk to show that they are dropped.
    task automatic set_config(logic [7:0] open_blink, logic [7:0] close_blink,
                              logic [7:0] error_blink, logic [11:0] timeout);
        write_reg(CFG_OPEN_BLINK, {4'($urandom_range(15)), open_blink});
        write_reg(CFG_CLOSE_BLINK, {4'($urandom_range(15)), close_blink});
        write_reg(CFG_ERROR_BLINK, {4'($urandom_range(15)), error_blink});
        write_reg(CFG_TRAVEL_TIMEOUT, timeout);
        cfg_shadow.open_blink     = open_blink;
        cfg_shadow.close_blink    = close_blink;
        cfg_shadow.error_blink    = error_blink;
        cfg_shadow.travel_timeout = timeout;
    endtask

    // Walks the gate through boot, every command, a limit conflict, both
    // travel ends, refused commands, a debounced button press and an unused
    // code, with the registers at their reset values.
    task automatic queue_directed();
        add_event(OP_GET, 1, 0, 0, 0);
        add_event(OP_BOOT, 1, 1, 1, 0);          // both limits: error at boot
        add_event(OP_TICK, 1, 0, 0, 0);          // error blink and buzzer toggle
        add_event(OP_BUZZ_OFF, 1, 0, 0, 0);
        add_event(OP_BUZZ_ON, 1, 0, 0, 0);
        add_event(OP_LAMP_ON, 1, 0, 0, 0);
        add_event(OP_LAMP_OFF, 1, 0, 0, 0);
        add_event(OP_STOP, 1, 0, 0, 0);          // leaves error, fault stays
        add_event(OP_RESET, 1, 0, 0, 1);
        add_event(OP_BOOT, 1, 1, 0, 0);          // boots open
        add_event(OP_OPEN, 1, 0, 0, 0);          // refused while open
        add_event(OP_CLOSE, 1, 0, 0, 0);
        add_event(OP_TICK, 1, 1, 0, 0);          // wrong end, keeps closing
        add_event(OP_TICK, 1, 0, 1, 0);          // reaches closed
        add_event(OP_PP, 1, 0, 0, 0);
        add_event(OP_TICK, 1, 1, 1, 0);          // conflict while moving
        add_event(OP_RESET, 1, 0, 0, 0);
        add_event(OP_BOOT, 1, 0, 1, 0);          // boots closed
        repeat (3) add_event(OP_TICK, 0, 0, 1, 0);  // press settles on the third
        add_event(OP_TICK, 0, 1, 0, 0);          // reaches open
        repeat (3) add_event(OP_TICK, 1, 1, 0, 0);  // release settles
        add_event(4'hF, 1, 1, 1, 0);             // unused code
    endtask

    // Random traffic is built from short scenes. The most common scene is a
    // whole travel from a start command or a button press to one of the limits,
    // so that the blink, timeout and stop logic see long runs of ticks.
    task automatic queue_random_traffic(int unsigned n_events);
        int unsigned start_count;
        int unsigned roll;
        int unsigned ticks;
        logic        noisy;
        logic        first_open;
        start_count = events_queued;
        while (events_queued - start_count < n_events)
        begin
            roll = $urandom_range(99);
            // Now and then the next scene waits for the block to go empty.
            if ($urandom_range(39) == 0)
                add_event(OP_GET, 1'($urandom_range(1)), 1'($urandom_range(1)),
                          1'($urandom_range(1)), 1);
            if (roll < 45)
            begin
                case ($urandom_range(3))
                    0:       add_event(OP_OPEN, 1, 0, 0, 0);
                    1:       add_event(OP_CLOSE, 1, 0, 0, 0);
                    2:       add_event(OP_PP, 1, 0, 0, 0);
                    default: repeat (3) add_event(OP_TICK, 0, 0, 0, 0);
                endcase
                if (cfg_shadow.travel_timeout <= 150 && $urandom_range(9) == 0)
                    ticks = cfg_shadow.travel_timeout + 1;
                else
                    ticks = $urandom_range(12);
                noisy = (ticks <= 12);
                repeat (ticks)
                    add_event(OP_TICK, !(noisy && $urandom_range(15) == 0),
                              noisy && $urandom_range(15) == 0,
                              noisy && $urandom_range(15) == 0, 0);
                if ($urandom_range(9) == 0)
                    add_event(OP_TICK, 1, 1, 1, 0);
                else
                begin
                    // Direction is not tracked here, so offer both ends.
                    first_open = 1'($urandom_range(1));
                    add_event(OP_TICK, 1, first_open, !first_open, 0);
                    add_event(OP_TICK, 1, !first_open, first_open, 0);
                end
            end
            else if (roll < 55)
                add_event(OP_BOOT, 1'($urandom_range(1)), 1'($urandom_range(1)),
                          1'($urandom_range(1)), 0);
            else if (roll < 67)
            begin
                add_event($urandom_range(1) ? OP_RESET : OP_STOP, 1'($urandom_range(1)),
                          1'($urandom_range(1)), 1'($urandom_range(1)), 0);
                if ($urandom_range(1))
                    add_event(OP_GET, 1, 0, 0, 0);
            end
            else if (roll < 77)
                repeat ($urandom_range(1, 6))
                    add_event(OP_TICK, 1, 1'($urandom_range(1)), 1'($urandom_range(1)), 0);
            else if (roll < 87)
                add_event(4'($urandom_range(OP_LAMP_ON, OP_GET)), 1'($urandom_range(1)),
                          1'($urandom_range(1)), 1'($urandom_range(1)), 0);
            else
                repeat ($urandom_range(1, 4))
                    add_event(4'($urandom_range(15)), 1'($urandom_range(1)),
                              1'($urandom_range(1)), 1'($urandom_range(1)), 0);
        end
    endtask

    initial
    begin
        rst_n                = 1'b0;
        cfg_we               = 1'b0;
        cfg_index            = '0;
        cfg_data             = '0;
        cmd_bus.valid        = 1'b0;
        cmd_bus.op           = '0;
        cmd_bus.button_level = 1'b1;
        cmd_bus.limit_open   = 1'b0;
        cmd_bus.limit_close  = 1'b0;
        res_bus.ready        = 1'b0;
        tx_idle_pct          = 7;
        rx_idle_pct          = 74;
        cfg_shadow.open_blink     = OPEN_BLINK_RESET;
        cfg_shadow.close_blink    = CLOSE_BLINK_RESET;
        cfg_shadow.error_blink    = ERROR_BLINK_RESET;
        cfg_shadow.travel_timeout = TRAVEL_TIMEOUT_RESET;

        queue_directed();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        wait_until_drained();

        // Shortest blink periods and a one-tick travel limit.
        set_config(8'd1, 8'd1, 8'd1, 12'd1);
        queue_random_traffic(340);
        wait_until_drained();

        // Sender busy, receiver mostly stalled is swapped from here on.
        tx_idle_pct = 74;
        rx_idle_pct = 7;
        // Zero periods toggle the lamp every tick; a zero timeout fails at once.
        set_config(8'd0, 8'd0, 8'd0, 12'd0);
        queue_random_traffic(340);
        wait_until_drained();

        set_config(8'd255, 8'd255, 8'd255, 12'd4095);
        queue_random_traffic(340);
        wait_until_drained();

        // Back-to-back traffic with no stalls on either side.
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        set_config(8'($urandom_range(255)), 8'($urandom_range(255)),
                   8'($urandom_range(255)), 12'($urandom_range(1, 200)));
        queue_random_traffic(340);
        wait_until_drained();

        set_config(8'd3, 8'd6, 8'd2, 12'd40);
        queue_random_traffic(340);
        wait_until_drained();

        if (outputs_due.size() != 0)
        begin
            $error("%0d results never arrived", outputs_due.size());
            error_count++;
        end
        if (error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
